### hdl/rpr_pkg.sv
// rpr_pkg: types, character codes and helpers shared by the packet receiver.
// No dependencies; imported by rpr_parser, rpr_resolver and ring_packet_receiver.
`timescale 1ns / 1ps

package rpr_pkg;

  localparam int ADDR_W = 11;
  localparam int MAG_W  = 16;

  // framing and header characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_UPPER_W = 8'h57;

  // byte positions inside a packet
  localparam logic [7:0] POS_HDR_FIRST = 8'd1;
  localparam logic [7:0] POS_HDR_LAST  = 8'd3;
  localparam logic [7:0] POS_DST_SIGN  = 8'd5;
  localparam logic [7:0] POS_DST_D100  = 8'd6;
  localparam logic [7:0] POS_DST_D10   = 8'd7;
  localparam logic [7:0] POS_DST_D1    = 8'd8;
  localparam logic [7:0] POS_SRC_SIGN  = 8'd10;
  localparam logic [7:0] POS_SRC_D100  = 8'd11;
  localparam logic [7:0] POS_SRC_D10   = 8'd12;
  localparam logic [7:0] POS_SRC_D1    = 8'd13;

  // packet status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // destination classes
  localparam logic [1:0] CL_LOCAL      = 2'd0;
  localparam logic [1:0] CL_BROADCAST  = 2'd1;
  localparam logic [1:0] CL_CONTROLLER = 2'd2;
  localparam logic [1:0] CL_FORWARD    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LOCAL      = 2'd0;
  localparam logic [1:0] REG_BROADCAST  = 2'd1;
  localparam logic [1:0] REG_CONTROLLER = 2'd2;

  localparam logic signed [ADDR_W-1:0] LOCAL_RST      = 11'sd0;
  localparam logic signed [ADDR_W-1:0] BROADCAST_RST  = 11'sd999;
  localparam logic signed [ADDR_W-1:0] CONTROLLER_RST = -11'sd999;

  // hop limits
  localparam logic signed [MAG_W-1:0] HOP_LO = -16'sd998;
  localparam logic signed [MAG_W-1:0] HOP_HI = 16'sd998;

  // finished packet handed from parser to resolver
  typedef struct packed {
    logic [1:0]       status;
    logic             dest_negative;
    logic [MAG_W-1:0] dest_magnitude;
    logic             source_negative;
    logic [MAG_W-1:0] source_magnitude;
  } rpr_event_t;

  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b <= CH_NINE) begin
      v = b - CH_ZERO;
    end else if (b <= CH_UPPER_F) begin
      v = b - CH_SEVEN;
    end else begin
      v = b - CH_UPPER_W;
    end
    return v;
  endfunction

  // acc + weight * (b - '0'), wrapping at 16 bits
  function automatic logic [MAG_W-1:0] add_digit(input logic [MAG_W-1:0] acc,
                                                 input logic [7:0] b,
                                                 input logic [MAG_W-1:0] weight);
    logic [MAG_W-1:0] d;
    logic [MAG_W-1:0] p;
    d = {8'd0, b} - {8'd0, CH_ZERO};
    p = d * weight;
    return acc + p;
  endfunction

endpackage

### hdl/rpr_parser.sv
// rpr_parser: per-byte framing, checksum and field collection; registers one
// event per finished packet. Depends on rpr_pkg.
`timescale 1ns / 1ps

module rpr_parser import rpr_pkg::*; #(
  parameter int MAX_PACKET_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_accept,
  input  logic [7:0] rx_byte,
  input  logic       ev_ready,
  output logic       ev_valid,
  output rpr_event_t ev
);

  localparam logic [7:0] STOP_POS = 8'(MAX_PACKET_LEN - 3);
  localparam logic [7:0] LAST_POS = 8'(MAX_PACKET_LEN - 1);

  logic             rx_mode;
  logic [7:0]       byte_count;
  logic [7:0]       running_sum;
  logic             sum_stopped;
  logic             star_seen;
  logic [1:0]       hex_digit_count;
  logic [7:0]       received_check;
  logic             header_ok;
  logic             dest_negative;
  logic [MAG_W-1:0] dest_magnitude;
  logic             source_negative;
  logic [MAG_W-1:0] source_magnitude;

  logic [7:0]       running_sum_next;
  logic             sum_stopped_next;
  logic             star_seen_next;
  logic [1:0]       hex_digit_count_next;
  logic [7:0]       received_check_next;
  logic             header_ok_next;
  logic             dest_negative_next;
  logic [MAG_W-1:0] dest_magnitude_next;
  logic             source_negative_next;
  logic [MAG_W-1:0] source_magnitude_next;

  logic       is_nl;
  logic       check_ok;
  logic       overflow;
  logic [7:0] hdr_char;

  always_comb begin
    is_nl = (rx_byte == CH_NL);

    unique case (byte_count)
      8'd1:    hdr_char = CH_S;
      8'd2:    hdr_char = CH_R;
      default: hdr_char = CH_N;
    endcase
    header_ok_next = header_ok;
    if (byte_count >= POS_HDR_FIRST && byte_count <= POS_HDR_LAST && rx_byte != hdr_char) begin
      header_ok_next = 1'b0;
    end

    dest_negative_next    = dest_negative;
    dest_magnitude_next   = dest_magnitude;
    source_negative_next  = source_negative;
    source_magnitude_next = source_magnitude;
    case (byte_count)
      POS_DST_SIGN: dest_negative_next  = (rx_byte == CH_MINUS);
      POS_DST_D100: dest_magnitude_next = add_digit(dest_magnitude, rx_byte, 16'd100);
      POS_DST_D10:  dest_magnitude_next = add_digit(dest_magnitude, rx_byte, 16'd10);
      POS_DST_D1:   dest_magnitude_next = add_digit(dest_magnitude, rx_byte, 16'd1);
      POS_SRC_SIGN: source_negative_next  = (rx_byte == CH_MINUS);
      POS_SRC_D100: source_magnitude_next = add_digit(source_magnitude, rx_byte, 16'd100);
      POS_SRC_D10:  source_magnitude_next = add_digit(source_magnitude, rx_byte, 16'd10);
      POS_SRC_D1:   source_magnitude_next = add_digit(source_magnitude, rx_byte, 16'd1);
      default: ;
    endcase

    received_check_next  = received_check;
    hex_digit_count_next = hex_digit_count;
    if (star_seen && hex_digit_count != 2'd2) begin
      received_check_next  = {received_check[3:0], 4'h0} + hex_value(rx_byte);
      hex_digit_count_next = hex_digit_count + 2'd1;
    end

    running_sum_next = running_sum;
    sum_stopped_next = sum_stopped;
    star_seen_next   = star_seen;
    if (!sum_stopped) begin
      if (rx_byte == CH_STAR) begin
        star_seen_next   = 1'b1;
        sum_stopped_next = 1'b1;
      end else if (byte_count >= STOP_POS) begin
        sum_stopped_next = 1'b1;
      end else if (rx_byte != CH_BAR) begin
        running_sum_next = running_sum + rx_byte;
      end
    end

    check_ok = header_ok_next && star_seen && hex_digit_count == 2'd2 &&
               received_check == running_sum;
    overflow = (byte_count >= LAST_POS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode          <= 1'b0;
      byte_count       <= 8'd0;
      running_sum      <= 8'd0;
      sum_stopped      <= 1'b0;
      star_seen        <= 1'b0;
      hex_digit_count  <= 2'd0;
      received_check   <= 8'd0;
      header_ok        <= 1'b1;
      dest_negative    <= 1'b0;
      dest_magnitude   <= '0;
      source_negative  <= 1'b0;
      source_magnitude <= '0;
    end else if (in_accept) begin
      if (!rx_mode) begin
        if (rx_byte == CH_DOLLAR) begin
          rx_mode          <= 1'b1;
          byte_count       <= 8'd1;
          running_sum      <= CH_DOLLAR;
          sum_stopped      <= 1'b0;
          star_seen        <= 1'b0;
          hex_digit_count  <= 2'd0;
          received_check   <= 8'd0;
          header_ok        <= 1'b1;
          dest_negative    <= 1'b0;
          dest_magnitude   <= '0;
          source_negative  <= 1'b0;
          source_magnitude <= '0;
        end
      end else begin
        // on newline only the field registers matter; the rest is cleared at next '$'
        byte_count       <= byte_count + 8'd1;
        running_sum      <= running_sum_next;
        sum_stopped      <= sum_stopped_next;
        star_seen        <= star_seen_next;
        hex_digit_count  <= hex_digit_count_next;
        received_check   <= received_check_next;
        header_ok        <= header_ok_next;
        dest_negative    <= dest_negative_next;
        dest_magnitude   <= dest_magnitude_next;
        source_negative  <= source_negative_next;
        source_magnitude <= source_magnitude_next;
        if (is_nl || overflow) begin
          rx_mode <= 1'b0;
        end
      end
    end
  end

  // event register; upstream only accepts when it is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      if (ev_ready) begin
        ev_valid <= 1'b0;
      end
      if (in_accept && rx_mode && (is_nl || overflow)) begin
        ev_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && rx_mode && (is_nl || overflow)) begin
      ev.status           <= is_nl ? (check_ok ? ST_ACCEPTED : ST_INVALID) : ST_OVERFLOW;
      ev.dest_negative    <= dest_negative_next;
      ev.dest_magnitude   <= dest_magnitude_next;
      ev.source_negative  <= source_negative_next;
      ev.source_magnitude <= source_magnitude_next;
    end
  end

endmodule

### hdl/rpr_resolver.sv
// rpr_resolver: hop adjustment and destination classing of a finished packet,
// held in the output register. Depends on rpr_pkg.
`timescale 1ns / 1ps

module rpr_resolver import rpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ev_valid,
  input  rpr_event_t               ev,
  output logic                     ev_ready,
  input  logic signed [ADDR_W-1:0] local_address,
  input  logic signed [ADDR_W-1:0] broadcast_address,
  input  logic signed [ADDR_W-1:0] controller_address,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [39:0]              m_tdata
);

  logic signed [MAG_W-1:0] dst;
  logic signed [MAG_W-1:0] src;
  logic signed [MAG_W-1:0] dst_adj;
  logic signed [MAG_W-1:0] src_adj;
  logic [1:0]              dest_class;
  logic [39:0]             result;

  assign ev_ready = !m_tvalid || m_tready;

  always_comb begin
    dst = ev.dest_negative   ? -$signed(ev.dest_magnitude)   : $signed(ev.dest_magnitude);
    src = ev.source_negative ? -$signed(ev.source_magnitude) : $signed(ev.source_magnitude);
    dst_adj = (dst > HOP_LO && dst <= HOP_HI) ? dst - 16'sd1 : dst;
    src_adj = (src >= HOP_LO && src < HOP_HI) ? src + 16'sd1 : src;

    if (dst_adj == MAG_W'(local_address)) begin
      dest_class = CL_LOCAL;
    end else if (dst_adj == MAG_W'(broadcast_address)) begin
      dest_class = CL_BROADCAST;
    end else if (dst_adj == MAG_W'(controller_address)) begin
      dest_class = CL_CONTROLLER;
    end else begin
      dest_class = CL_FORWARD;
    end

    if (ev.status == ST_ACCEPTED) begin
      result = {4'd0, src_adj, dst_adj, dest_class, ev.status};
    end else begin
      result = {38'd0, ev.status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ev_ready) begin
      m_tvalid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) begin
      m_tdata <= result;
    end
  end

endmodule

### hdl/ring_packet_receiver.sv
// ring_packet_receiver: top level; address registers, parser and resolver.
// Depends on rpr_pkg, rpr_parser, rpr_resolver.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata[7:0]  rx_byte
//   m_*      out  m_tvalid/m_tready    m_tdata[39:0] status, class, new_dest, new_source
//   cfg_*    in   cfg_we               cfg_index, cfg_wdata
//
// One byte is taken every cycle while s_tready is high. A packet's result reaches m_*
// after the byte that ends it (newline or length limit) by way of the parser event
// register, then the resolver output register.
// Reset returns the parser to scanning and the addresses to 0, 999, -999.
// s_tready drops only when both the event and output registers are full and
// m_tready is low.
`timescale 1ns / 1ps

module ring_packet_receiver import rpr_pkg::*; #(
  parameter int MAX_PACKET_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [1:0] packet_status, [3:2] dest_class,
                                       // [19:4] new_dest, [35:20] new_source
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic signed [ADDR_W-1:0] local_address;
  logic signed [ADDR_W-1:0] broadcast_address;
  logic signed [ADDR_W-1:0] controller_address;

  logic       in_accept;
  logic       ev_valid;
  logic       ev_ready;
  rpr_event_t ev;

  assign s_tready  = !ev_valid || ev_ready;
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address      <= LOCAL_RST;
      broadcast_address  <= BROADCAST_RST;
      controller_address <= CONTROLLER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCAL:      local_address      <= $signed(cfg_wdata);
        REG_BROADCAST:  broadcast_address  <= $signed(cfg_wdata);
        REG_CONTROLLER: controller_address <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  rpr_parser #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_accept),
    .rx_byte  (s_tdata),
    .ev_ready (ev_ready),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  rpr_resolver u_resolver (
    .clk               (clk),
    .rst               (rst),
    .ev_valid          (ev_valid),
    .ev                (ev),
    .ev_ready          (ev_ready),
    .local_address     (local_address),
    .broadcast_address (broadcast_address),
    .controller_address(controller_address),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata)
  );

  // input stalls only when both stages hold a result
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (ev_valid && m_tvalid && !m_tready))
    else $error("input stalled with room downstream");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_ACCEPTED || m_tdata[1:0] == ST_INVALID ||
                  m_tdata[1:0] == ST_OVERFLOW))
    else $error("undefined packet status");

  a_reject_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ST_ACCEPTED) |-> (m_tdata[39:2] == 38'd0))
    else $error("rejected packet carries nonzero fields");

  a_event_moves: assert property (@(posedge clk) disable iff (rst)
    (ev_valid && ev_ready) |=> m_tvalid)
    else $error("event lost between parser and output register");

endmodule

### dv/tb.sv
// tb: self-checking bench for ring_packet_receiver. Streams framed packets, line noise
// and damaged packets into the byte port and checks each packet result against a predictor.
// Depends on rpr_pkg and the ring_packet_receiver RTL.
`timescale 1ns / 1ps

import rpr_pkg::*;

localparam int PACKET_LIMIT = 64;
localparam logic [1:0] REG_UNUSED = 2'd3;   // no register here; writes must be dropped
localparam logic [7:0] CH_PLUS    = 8'h2B;
localparam logic [7:0] CH_COMMA   = 8'h2C;
localparam logic [7:0] CH_UPPER_A = 8'h41;
localparam logic [7:0] CH_LOWER_A = 8'h61;

typedef struct {
  logic [1:0]  status;
  logic [1:0]  cls;
  logic [15:0] dest;
  logic [15:0] source;
} packet_result_t;

class packet_checker;
  logic signed [ADDR_W-1:0] local_addr = LOCAL_RST;
  logic signed [ADDR_W-1:0] bcast_addr = BROADCAST_RST;
  logic signed [ADDR_W-1:0] ctrl_addr  = CONTROLLER_RST;

  bit          in_packet;
  logic [7:0]  count;
  logic [7:0]  sum;
  bit          sum_done;
  bit          star_found;
  int          hex_digits;
  logic [7:0]  check_byte;
  bit          header_good;
  bit          dest_neg;
  logic [15:0] dest_mag;
  bit          src_neg;
  logic [15:0] src_mag;

  packet_result_t pending[$];
  int errors;
  int bytes_seen;
  int packet_bytes;
  int by_status[3];

  function void set_register(logic [1:0] idx, logic [ADDR_W-1:0] val);
    case (idx)
      REG_LOCAL:      local_addr = val;
      REG_BROADCAST:  bcast_addr = val;
      REG_CONTROLLER: ctrl_addr  = val;
      default: ;
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) $display("tb: mismatch: %s", msg);
  endtask

  function logic [15:0] weighted_digit(logic [7:0] b, int weight);
    return 16'(weight * (int'(b) - int'(CH_ZERO)));
  endfunction

  function void note_byte(logic [7:0] b);
    logic [7:0] pos;
    logic [7:0] nib;
    int dst;
    int src;
    packet_result_t r;
    bytes_seen++;
    if (!in_packet) begin
      if (b == CH_DOLLAR) begin
        in_packet   = 1;
        count       = 8'd1;
        sum         = b;
        sum_done    = 0;
        star_found  = 0;
        hex_digits  = 0;
        check_byte  = '0;
        header_good = 1;
        dest_neg    = 0;
        dest_mag    = '0;
        src_neg     = 0;
        src_mag     = '0;
      end
      return;
    end
    packet_bytes++;
    pos = count;
    if (pos == POS_HDR_FIRST && b != CH_S) header_good = 0;
    if (pos == POS_HDR_FIRST + 8'd1 && b != CH_R) header_good = 0;
    if (pos == POS_HDR_LAST && b != CH_N) header_good = 0;
    case (pos)
      POS_DST_SIGN: dest_neg = (b == CH_MINUS);
      POS_DST_D100: dest_mag += weighted_digit(b, 100);
      POS_DST_D10:  dest_mag += weighted_digit(b, 10);
      POS_DST_D1:   dest_mag += weighted_digit(b, 1);
      POS_SRC_SIGN: src_neg = (b == CH_MINUS);
      POS_SRC_D100: src_mag += weighted_digit(b, 100);
      POS_SRC_D10:  src_mag += weighted_digit(b, 10);
      POS_SRC_D1:   src_mag += weighted_digit(b, 1);
      default: ;
    endcase

    if (b == CH_NL) begin
      in_packet = 0;
      r.status = ST_INVALID;
      r.cls    = '0;
      r.dest   = '0;
      r.source = '0;
      if (header_good && star_found && hex_digits == 2 && check_byte == sum) begin
        dst = $signed(dest_mag);
        src = $signed(src_mag);
        if (dest_neg) dst = -dst;
        if (src_neg) src = -src;
        // hop limits: ends of the address range are left untouched
        if (dst > -998 && dst < 999) dst--;
        if (src > -999 && src < 998) src++;
        r.status = ST_ACCEPTED;
        if (dst == local_addr) r.cls = CL_LOCAL;
        else if (dst == bcast_addr) r.cls = CL_BROADCAST;
        else if (dst == ctrl_addr) r.cls = CL_CONTROLLER;
        else r.cls = CL_FORWARD;
        r.dest   = 16'(dst);
        r.source = 16'(src);
      end
      pending.push_back(r);
      return;
    end

    if (star_found && hex_digits < 2) begin
      if (b <= CH_NINE) nib = b - CH_ZERO;
      else if (b <= CH_UPPER_F) nib = b - CH_SEVEN;
      else nib = b - CH_UPPER_W;
      check_byte = {check_byte[3:0], 4'b0000} + nib;
      hex_digits++;
    end
    if (!sum_done) begin
      if (b == CH_STAR) begin
        star_found = 1;
        sum_done   = 1;
      end else if (pos >= PACKET_LIMIT - 3) begin
        sum_done = 1;
      end else if (b != CH_BAR) begin
        sum += b;
      end
    end

    count = pos + 8'd1;
    if (int'(pos) + 1 >= PACKET_LIMIT) begin
      in_packet = 0;
      r.status = ST_OVERFLOW;
      r.cls    = '0;
      r.dest   = '0;
      r.source = '0;
      pending.push_back(r);
    end
  endfunction

  task check_result(logic [39:0] d);
    packet_result_t e;
    if (pending.size() == 0) begin
      report($sformatf("result %h arrived with none expected", d));
      return;
    end
    e = pending.pop_front();
    if (e.status <= ST_OVERFLOW) by_status[e.status]++;
    if (d[1:0] != e.status)
      report($sformatf("status %0d, expected %0d", d[1:0], e.status));
    if (d[3:2] != e.cls)
      report($sformatf("dest class %0d, expected %0d", d[3:2], e.cls));
    if (d[19:4] != e.dest)
      report($sformatf("new dest %0d, expected %0d", $signed(d[19:4]), $signed(e.dest)));
    if (d[35:20] != e.source)
      report($sformatf("new source %0d, expected %0d", $signed(d[35:20]),
                       $signed(e.source)));
  endtask
endclass

module tb;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 180;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int QUIET_CYCLES = 8;

  typedef enum int {
    DEFECT_NONE, DEFECT_HEADER, DEFECT_CHECKSUM, DEFECT_NO_STAR,
    DEFECT_ONE_HEX, DEFECT_TRUNCATE, DEFECT_OVERFLOW, DEFECT_STRAY_BYTE
  } defect_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'd0;      // [7:0] rx_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;             // [1:0] status, [3:2] class, [19:4] dest,
                                          // [35:20] source
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_LOCAL;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  packet_checker rx_check;
  logic [7:0]    sentence[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_requests = 0;
  int            holds_done = 0;
  int            hold_left = 0;

  ring_packet_receiver #(.MAX_PACKET_LEN(PACKET_LIMIT)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != holds_done) begin
      holds_done <= hold_requests;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // handshake signals are stable by the falling edge; a request seen here
  // completes at the next rising edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) rx_check.check_result(m_tdata);
  end

  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    rx_check.note_byte(b);
  endtask

  task automatic transmit();
    foreach (sentence[i]) send_byte(sentence[i]);
  endtask

  // stop sending and wait until every expected result has come out or DRAIN_LIMIT is reached
  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (rx_check.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic load_addresses(input int l, input int b, input int c);
    logic [ADDR_W-1:0] junk;
    junk = ADDR_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOCAL;
    cfg_wdata <= ADDR_W'(l);
    @(posedge clk);
    rx_check.set_register(REG_LOCAL, ADDR_W'(l));
    cfg_index <= REG_BROADCAST;
    cfg_wdata <= ADDR_W'(b);
    @(posedge clk);
    rx_check.set_register(REG_BROADCAST, ADDR_W'(b));
    cfg_index <= REG_CONTROLLER;
    cfg_wdata <= ADDR_W'(c);
    @(posedge clk);
    rx_check.set_register(REG_CONTROLLER, ADDR_W'(c));
    // written last so a decode slip would clobber a live register
    cfg_index <= REG_UNUSED;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_field(input int v);
    int mag;
    mag = (v < 0) ? -v : v;
    sentence.push_back((v < 0) ? CH_MINUS : CH_PLUS);
    sentence.push_back(8'(mag / 100) + CH_ZERO);
    sentence.push_back(8'((mag / 10) % 10) + CH_ZERO);
    sentence.push_back(8'(mag % 10) + CH_ZERO);
  endfunction

  function automatic void start_sentence(input int dst, input int src);
    sentence.delete();
    sentence.push_back(CH_DOLLAR);
    sentence.push_back(CH_S);
    sentence.push_back(CH_R);
    sentence.push_back(CH_N);
    sentence.push_back(CH_COMMA);
    push_field(dst);
    sentence.push_back(CH_COMMA);
    push_field(src);
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = ($urandom_range(7) == 0) ? CH_BAR : 8'($urandom);
    while (b == CH_NL || b == CH_STAR) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return CH_ZERO + 8'(n);
    return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic void finish_sentence(input bit lower);
    logic [7:0] total;
    total = '0;
    foreach (sentence[i]) if (sentence[i] != CH_BAR) total += sentence[i];
    sentence.push_back(CH_STAR);
    sentence.push_back(hex_char(total[7:4], lower));
    sentence.push_back(hex_char(total[3:0], lower));
    sentence.push_back(CH_NL);
  endfunction

  function automatic void cut_to(input int len);
    while (sentence.size() > len) void'(sentence.pop_back());
  endfunction

  function automatic int pick_dest();
    int v;
    int ends[6] = '{-999, -998, -997, 0, 998, 999};
    case ($urandom_range(6))
      0, 1: v = int'($urandom_range(1998)) - 999;
      2: v = ends[$urandom_range(5)];
      3: v = rx_check.local_addr + 1;
      4: v = rx_check.bcast_addr + int'($urandom_range(1));
      5: v = rx_check.ctrl_addr + int'($urandom_range(1));
      default: v = int'($urandom_range(20)) - 10;
    endcase
    if (v > 999) v = 999;
    if (v < -999) v = -999;
    return v;
  endfunction

  function automatic int pick_source();
    int ends[6] = '{-999, -998, -997, 997, 998, 999};
    if ($urandom_range(3) == 0) return ends[$urandom_range(5)];
    return int'($urandom_range(1998)) - 999;
  endfunction

  task automatic send_random_packet();
    defect_t defect;
    int n;
    start_sentence(pick_dest(), pick_source());
    n = ($urandom_range(9) == 0) ? 40 + $urandom_range(6) : $urandom_range(12);
    repeat (n) sentence.push_back(payload_byte());
    finish_sentence($urandom_range(1));
    defect = defect_t'($urandom_range(7));
    if ($urandom_range(1) == 0) defect = DEFECT_NONE;
    case (defect)
      DEFECT_HEADER:   sentence[1 + $urandom_range(2)] = 8'($urandom);
      DEFECT_CHECKSUM: sentence[sentence.size() - 2 - $urandom_range(1)] ^=
                         8'd1 << $urandom_range(7);
      DEFECT_NO_STAR:  sentence[sentence.size() - 4] = payload_byte();
      DEFECT_ONE_HEX:  sentence.delete(sentence.size() - 2);
      DEFECT_TRUNCATE: begin
        cut_to(1 + $urandom_range(sentence.size() - 2));
        sentence.push_back(CH_NL);
      end
      DEFECT_OVERFLOW: begin
        void'(sentence.pop_back());
        n = PACKET_LIMIT + $urandom_range(3);
        while (sentence.size() < n) sentence.push_back(payload_byte());
      end
      DEFECT_STRAY_BYTE: sentence[1 + $urandom_range(sentence.size() - 2)] = 8'($urandom);
      default: ;
    endcase
    // line noise ahead of the frame
    if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
    transmit();
  endtask

  task automatic run_directed();
    // bytes outside a frame are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NL);
    send_byte(CH_STAR);
    // hop arithmetic at the range ends, classes under reset addresses
    start_sentence(999, -999);  finish_sentence(0); transmit();
    start_sentence(-998, 998);  finish_sentence(1); transmit();
    start_sentence(-997, -998); finish_sentence(0); transmit();
    start_sentence(1, 997);     finish_sentence(0); transmit();
    start_sentence(-999, 5);    finish_sentence(1); transmit();
    // bad header
    start_sentence(5, 5);
    sentence[POS_HDR_LAST] = CH_S;
    finish_sentence(0);
    transmit();
    // wrong checksum
    start_sentence(10, 20);
    finish_sentence(0);
    sentence[sentence.size() - 2] ^= 8'd1;
    transmit();
    // no star at all
    start_sentence(10, 20);
    sentence.push_back(CH_NL);
    transmit();
    // newline right after the first hex digit
    start_sentence(10, 20);
    finish_sentence(0);
    sentence.delete(sentence.size() - 2);
    transmit();
    // short frames: newline inside the header, newline at a digit position
    start_sentence(0, 0);
    cut_to(3);
    sentence.push_back(CH_NL);
    transmit();
    start_sentence(-123, 0);
    cut_to(7);
    sentence.push_back(CH_NL);
    transmit();
    // length limit with no newline
    sentence.delete();
    sentence.push_back(CH_DOLLAR);
    repeat (PACKET_LIMIT - 1) sentence.push_back(payload_byte());
    transmit();
    // star at the last position that still leaves room for the newline
    start_sentence(0, 0);
    while (sentence.size() < PACKET_LIMIT - 4) sentence.push_back(payload_byte());
    finish_sentence(1);
    transmit();
    // star one later: overflow hits on the second hex digit
    start_sentence(0, 0);
    while (sentence.size() < PACKET_LIMIT - 3) sentence.push_back(payload_byte());
    finish_sentence(0);
    transmit();
    // non-digit bytes in digit slots, non-minus sign byte
    start_sentence(0, 0);
    sentence[POS_DST_D100] = 8'hFF;
    sentence[POS_SRC_SIGN] = CH_BAR;
    sentence[POS_SRC_D10]  = CH_UPPER_W;
    finish_sentence(0);
    transmit();
  endtask

  initial begin
    int phase;
    int start_bytes;
    bit done_once;
    int r;
    rx_check = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();

    for (phase = 0; phase < 6; phase++) begin
      settle();
      r = int'($urandom_range(1998)) - 999;
      case (phase)
        0: load_addresses(999, -999, 0);
        1: load_addresses(-999, 999, -998);
        2: load_addresses(r, r, int'($urandom_range(1998)) - 999);
        default: load_addresses(r, int'($urandom_range(1998)) - 999,
                                int'($urandom_range(1998)) - 999);
      endcase
      case (phase)
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        3, 5: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      start_bytes = rx_check.packet_bytes;
      done_once = 0;
      while (rx_check.packet_bytes - start_bytes < PHASE_BYTES) begin
        send_random_packet();
        if (!done_once && rx_check.packet_bytes - start_bytes > 100) begin
          done_once = 1;
          if (phase == 4) begin
            // long receiver hold-off while short frames keep coming
            hold_requests <= hold_requests + 1;
            repeat (12) begin
              send_byte(CH_DOLLAR);
              send_byte(CH_NL);
            end
          end else if (phase == 3) begin
            settle();
          end
        end
      end
      // close any open frame so the block is back to scanning
      send_byte(CH_NL);
    end

    settle();
    if (rx_check.pending.size() != 0)
      rx_check.report($sformatf("%0d results never arrived", rx_check.pending.size()));
    $display("tb: %0d bytes sent, %0d inside frames, reset plus 6 address settings",
             rx_check.bytes_seen, rx_check.packet_bytes);
    $display("tb: results: %0d accepted, %0d invalid, %0d overflow",
             rx_check.by_status[ST_ACCEPTED], rx_check.by_status[ST_INVALID],
             rx_check.by_status[ST_OVERFLOW]);
    if (rx_check.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
